### sv/frm_pkg.sv
package frm_pkg;

	// default parameter values
	localparam int TIME_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 8;

	// fixed field widths
	localparam int WIN_W   = 8;
	localparam int FIRST_W = 20;
	localparam int SUM_W   = 40;
	localparam int RATE_W  = 28;
	localparam int SHOWN_W = 8;
	localparam int CFG_W   = 20;

	// 1e6 us per second, times 256 for the 1/256 fps unit
	localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(256000000);
	localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(256000000);

	localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(60);
	localparam logic [FIRST_W-1:0] FIRST_RST  = FIRST_W'(16666);

	typedef enum logic [0:0] {
		CFG_WINDOW = 1'b0,
		CFG_FIRST  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} frm_state_t;

	typedef struct packed {
		logic accum;     // take a timestamp, update sum and count
		logic mul;       // form the scaled numerator, arm the divider
		logic div_step;  // one quotient bit
		logic load_out;  // write the result register
	} frm_cmd_t;

	typedef struct packed {
		logic done;      // the last item closed a window
		logic div_last;  // final divider step in progress
	} frm_sts_t;

endpackage

### sv/frm_ifs.sv
interface frm_stamp_if #(
	parameter int TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] now_time;

	modport source (output valid, output now_time, input ready);
	modport sink   (input valid, input now_time, output ready);
endinterface

interface frm_rate_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frames_in_window;
	logic        window_done;
	logic [27:0] average_rate;

	modport source (output valid, output frames_in_window, output window_done,
		output average_rate, input ready);
	modport sink   (input valid, input frames_in_window, input window_done,
		input average_rate, output ready);
endinterface

### sv/frm_ctrl.sv
module frm_ctrl
	import frm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output frm_cmd_t cmd,
	input  frm_sts_t sts
);

	frm_state_t state_q, state_nxt;
	logic       out_full_q;
	logic       out_free;

	assign out_free  = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = sts.done ? ST_MUL : ST_FINISH;
			end
			ST_MUL: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

endmodule

### sv/frm_datapath.sv
module frm_datapath
	import frm_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [TIME_BITS-1:0] now_time,
	input  frm_cmd_t             cmd,
	output frm_sts_t             sts,
	output logic [SHOWN_W-1:0]   frames_in_window,
	output logic                 window_done,
	output logic [RATE_W-1:0]    average_rate
);

	localparam int PER_W  = (TIME_BITS > FIRST_W) ? TIME_BITS : FIRST_W;
	localparam int ADD_W  = ((PER_W > SUM_W) ? PER_W : SUM_W) + 1;
	localparam int CMP_W  = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
	localparam int NUM_W  = RATE_W + COUNT_BITS;
	localparam int STEP_W = $clog2(NUM_W);
	localparam logic [ADD_W-1:0] SUM_MAX_X = {{(ADD_W-SUM_W){1'b0}}, {SUM_W{1'b1}}};

	// configuration
	logic [WIN_W-1:0]   window_q;
	logic [FIRST_W-1:0] first_q;

	// running state
	logic [TIME_BITS-1:0]  prev_time_q;
	logic                  seen_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [RATE_W-1:0]     held_rate_q;

	// per-item registers
	logic                  done_q;
	logic [SHOWN_W-1:0]    shown_q;
	logic [COUNT_BITS-1:0] div_count_q;
	logic [SUM_W-1:0]      div_sum_q;

	// divider
	logic [NUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;

	// output register
	logic [SHOWN_W-1:0] out_shown_q;
	logic               out_done_q;
	logic [RATE_W-1:0]  out_rate_q;

	logic [TIME_BITS-1:0]  diff;
	logic [PER_W-1:0]      period;
	logic [ADD_W-1:0]      total;
	logic [SUM_W-1:0]      sum_nxt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic [CMP_W-1:0]      cnt_x;
	logic                  done_nxt;
	logic [SUM_W:0]        trial;
	logic                  q_bit;
	logic [RATE_W-1:0]     rate_sat;
	logic [RATE_W-1:0]     rate_nxt;

	assign diff   = now_time - prev_time_q;
	assign period = seen_q ? PER_W'(diff) : PER_W'(first_q);
	assign total  = ADD_W'(sum_q) + ADD_W'(period);
	assign sum_nxt = (total > SUM_MAX_X) ? {SUM_W{1'b1}} : total[SUM_W-1:0];

	assign cnt_inc = count_q + COUNT_BITS'(1);
	assign cnt_nxt = (cnt_inc == '0) ? COUNT_BITS'(1) : cnt_inc;
	assign cnt_x   = CMP_W'(cnt_nxt);
	// a full counter closes the window even if the window is longer
	assign done_nxt = (cnt_x >= CMP_W'(window_q)) || (cnt_nxt == {COUNT_BITS{1'b1}});

	// restoring division, one quotient bit per cycle shifted into num_q
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign q_bit = trial >= {1'b0, div_sum_q};

	assign rate_sat = (num_q > NUM_W'(RATE_MAX)) ? RATE_MAX : num_q[RATE_W-1:0];
	assign rate_nxt = !done_q ? held_rate_q
		: (div_sum_q == '0) ? '0 : rate_sat;

	assign sts.done     = done_q;
	assign sts.div_last = step_q == STEP_W'(NUM_W - 1);

	assign frames_in_window = out_shown_q;
	assign window_done      = out_done_q;
	assign average_rate     = out_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RST;
			first_q     <= FIRST_RST;
			prev_time_q <= '0;
			seen_q      <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
			held_rate_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					CFG_FIRST:  first_q  <= cfg_data[FIRST_W-1:0];
					default:    window_q <= window_q;
				endcase
			end
			if (cmd.accum) begin
				prev_time_q <= now_time;
				seen_q      <= 1'b1;
				if (done_nxt) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					count_q <= cnt_nxt;
				end
			end
			if (cmd.load_out) held_rate_q <= rate_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			done_q      <= done_nxt;
			shown_q     <= cnt_x[SHOWN_W-1:0];
			div_count_q <= cnt_nxt;
			div_sum_q   <= sum_nxt;
		end
		if (cmd.mul) begin
			num_q  <= NUM_W'(RATE_SCALE) * NUM_W'(div_count_q);
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			num_q  <= {num_q[NUM_W-2:0], q_bit};
			rem_q  <= q_bit ? SUM_W'(trial - {1'b0, div_sum_q}) : trial[SUM_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.load_out) begin
			out_shown_q <= shown_q;
			out_done_q  <= done_q;
			out_rate_q  <= rate_nxt;
		end
	end

endmodule

### sv/frame_rate_meter_top.sv
// An item is accepted in IDLE and goes to DECIDE; an item that closes a window also passes MUL
// and DIV (bit-serial divider, one quotient bit a cycle) before FINISH loads the result register.
// A new item is accepted only once the last one has left FINISH;
// the result register lets the next item in while a result waits.
// Reset (arst_n low, asynchronous): sum, count, previous time and held rate cleared,
// window_frames = 60, first_period = 16666.
module frame_rate_meter_top
	import frm_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	frm_stamp_if.sink        stamp,
	frm_rate_if.source       result
);

	frm_cmd_t cmd;
	frm_sts_t sts;

	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stamp.valid),
		.in_ready  (stamp.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	frm_datapath #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.now_time         (stamp.now_time),
		.cmd              (cmd),
		.sts              (sts),
		.frames_in_window (result.frames_in_window),
		.window_done      (result.window_done),
		.average_rate     (result.average_rate)
	);

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import frm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [SUM_W-1:0] SUM_FULL = {SUM_W{1'b1}};
	localparam logic [SHOWN_W-1:0] COUNT_FULL = {SHOWN_W{1'b1}};

	typedef struct packed {
		logic [SHOWN_W-1:0] frames;
		logic               done;
		logic [RATE_W-1:0]  rate;
	} rate_res_t;

	typedef enum bit {ROW_STAMP, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_idx_t           idx;
		logic [CFG_W-1:0]   data;
		logic [31:0]        stamp;
		logic               typed;
		rate_res_t          want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	frm_stamp_if #(.TIME_BITS(32)) stamp_if();
	frm_rate_if rate_if();

	frame_rate_meter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stamp     (stamp_if),
		.result    (rate_if)
	);

	// predictor state and its copy of the registers
	logic [31:0]        prev_stamp = '0;
	logic               have_first = 1'b0;
	logic [SUM_W-1:0]   period_acc = '0;
	logic [SHOWN_W-1:0] frame_tally = '0;
	logic [RATE_W-1:0]  rate_held = '0;
	logic [WIN_W-1:0]   win_len = WINDOW_RST;
	logic [FIRST_W-1:0] first_us = FIRST_RST;

	rate_res_t pending_rates[$];
	dir_row_t  directed_rows [0:22];
	int        phase_win [8] = '{60, 1, 255, 4, 0, 17, 2, 0};
	int        phase_len [8] = '{150, 150, 300, 140, 150, 140, 130, 140};

	int          mismatches = 0;
	int          stamps_sent = 0;
	int          results_seen = 0;
	int          windows_closed = 0;
	int          cycle_count = 0;
	bit          snd_idle = 1'b0;
	bit          rcv_stall = 1'b0;
	int          idle_pct = 59;
	bit          hold_start = 1'b0;
	int          hold_left = 0;
	logic [31:0] stamp_run = 32'd100000;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rate_res_t predict_rate(logic [31:0] t);
		logic [31:0]     period;
		longint unsigned quot;
		rate_res_t       r;
		period = have_first ? t - prev_stamp : 32'(first_us);
		prev_stamp = t;
		have_first = 1'b1;
		if (SUM_W'(period) > SUM_FULL - period_acc)
			period_acc = SUM_FULL;
		else
			period_acc = period_acc + SUM_W'(period);
		frame_tally = frame_tally + SHOWN_W'(1);
		if (frame_tally == '0)
			frame_tally = SHOWN_W'(1);
		r.frames = frame_tally;
		r.done = (frame_tally >= win_len) || (frame_tally == COUNT_FULL);
		if (r.done) begin
			if (period_acc == '0) begin
				rate_held = '0;
			end else begin
				quot = (64'(RATE_SCALE) * 64'(frame_tally)) / 64'(period_acc);
				rate_held = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
			end
			period_acc = '0;
			frame_tally = '0;
		end
		r.rate = rate_held;
		return r;
	endfunction

	// mostly steady frame periods with jitter, plus duplicates, tiny
	// periods, jumps to random times and runs up to the counter wrap
	function automatic logic [31:0] next_stamp();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			stamp_run = stamp_run + 32'(15000 + $urandom_range(3400));
		else if (pick < 70)
			stamp_run = stamp_run + 32'($urandom_range(1, 200000));
		else if (pick < 82)
			stamp_run = stamp_run + 32'($urandom_range(0, 3));
		else if (pick < 92)
			stamp_run = $urandom;
		else
			stamp_run = 32'hFFFF_FFFF - 32'($urandom_range(60000));
		return stamp_run;
	endfunction

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic send_stamp(logic [31:0] t, logic typed, rate_res_t typed_res);
		rate_res_t r;
		@(negedge clk);
		while (snd_idle && $urandom_range(99) < idle_pct) begin
			stamp_if.valid <= 1'b0;
			@(negedge clk);
		end
		stamp_if.valid <= 1'b1;
		stamp_if.now_time <= t;
		do @(posedge clk); while (!stamp_if.ready);
		r = predict_rate(t);
		pending_rates.push_back(typed ? typed_res : r);
		stamps_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		stamp_if.valid <= 1'b0;
		while (pending_rates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WINDOW: win_len = v[WIN_W-1:0];
			CFG_FIRST:  first_us = v[FIRST_W-1:0];
			default: ;
		endcase
	endtask

	// receiver: random stalls, plus one long hold to back the block up
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rate_if.ready <= 1'b0;
		end else begin
			rate_if.ready <= !(rcv_stall && $urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin : rate_monitor
		rate_res_t want;
		if (arst_n && rate_if.valid && rate_if.ready) begin
			results_seen++;
			if (rate_if.window_done)
				windows_closed++;
			if (pending_rates.size() == 0) begin
				flag_mismatch("result with nothing pending", rate_if.frames_in_window, 0);
			end else begin
				want = pending_rates.pop_front();
				if (rate_if.frames_in_window !== want.frames)
					flag_mismatch("frames_in_window", rate_if.frames_in_window, want.frames);
				if (rate_if.window_done !== want.done)
					flag_mismatch("window_done", rate_if.window_done, want.done);
				if (rate_if.average_rate !== want.rate)
					flag_mismatch("average_rate", rate_if.average_rate, want.rate);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stalled: %0d results still pending after %0d cycles",
				pending_rates.size(), cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int p;
		int i;
		rate_res_t none;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_data = '0;
		stamp_if.valid = 1'b0;
		stamp_if.now_time = '0;
		rate_if.ready = 1'b0;

		// first frame uses the reset first_period; window 0 acts like 1
		directed_rows = '{
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0000, 1'b1, '{8'd1, 1'b0, 28'd0}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'hFFFF_FFFF, 1'b1, '{8'd2, 1'b0, 28'd0}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0010, 1'b1, '{8'd3, 1'b0, 28'd0}},
			'{ROW_WRITE, CFG_WINDOW, 20'd1, 32'h0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0020, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0020, 1'b1, '{8'd1, 1'b1, 28'd0}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0021, 1'b1, '{8'd1, 1'b1, RATE_MAX}},
			'{ROW_WRITE, CFG_WINDOW, 20'd2, 32'h0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0021, 1'b1, '{8'd1, 1'b0, RATE_MAX}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_0022, 1'b1, '{8'd2, 1'b1, RATE_MAX}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h5555_5555, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'hAAAA_AAAA, 1'b0, '0},
			'{ROW_WRITE, CFG_WINDOW, 20'd0, 32'h0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'hAAAA_AAAA, 1'b1, '{8'd1, 1'b1, 28'd0}},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'hAAAB_0000, 1'b0, '0},
			'{ROW_WRITE, CFG_FIRST, 20'd0, 32'h0, 1'b0, '0},
			'{ROW_WRITE, CFG_FIRST, 20'd1000000, 32'h0, 1'b0, '0},
			'{ROW_WRITE, CFG_WINDOW, 20'd255, 32'h0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'hFFFF_FFF0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_000F, 1'b0, '0},
			'{ROW_WRITE, CFG_WINDOW, 20'd3, 32'h0, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_411F, 1'b0, '0},
			'{ROW_STAMP, CFG_WINDOW, 20'd0, 32'h0000_82F0, 1'b0, '0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(directed_rows[k].idx, directed_rows[k].data);
			end else begin
				send_stamp(directed_rows[k].stamp, directed_rows[k].typed,
					directed_rows[k].want);
			end
		end

		for (p = 0; p < 8; p++) begin
			wait_drained();
			write_reg(CFG_WINDOW, (p == 7) ? CFG_W'($urandom_range(1, 255))
				: CFG_W'(phase_win[p]));
			case (p)
				0: write_reg(CFG_FIRST, 20'd0);
				1: write_reg(CFG_FIRST, 20'd1000000);
				default: write_reg(CFG_FIRST, CFG_W'($urandom_range(1000000)));
			endcase
			snd_idle = (p % 4 == 1) || (p % 4 == 3);
			rcv_stall = (p % 4 >= 2);
			// lighter idling when both sides pause
			idle_pct = (p % 4 == 3) ? 27 : 59;
			// long receiver hold with the sender running flat out
			if (p == 4)
				hold_start = 1'b1;
			for (i = 0; i < phase_len[p]; i++) begin
				if (p == 5 && i == 60)
					wait_drained();
				send_stamp(next_stamp(), 1'b0, none);
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (pending_rates.size() != 0)
			flag_mismatch("results never delivered", 0, pending_rates.size());
		$display("Run covered %0d timestamps and %0d rate results, %0d of them closing a window,",
			stamps_sent, results_seen, windows_closed);
		$display("over windows of 0 to 255 frames, counter wrap, zero sums and rate clipping.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
sv/frm_pkg.sv
sv/frm_ifs.sv
sv/frm_ctrl.sv
sv/frm_datapath.sv
sv/frame_rate_meter_top.sv
dv/tb.sv
